[rtl/fspa_pkg.sv]
// Shared types and constants for the fixed slot pool allocator.
`default_nettype none

package fspa_pkg;

  localparam int MAX_SLOTS_DEF = 32;
  localparam int SLOT_W        = 5;
  localparam int CNT_W         = 32;
  localparam int ACT_W         = 6;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [ACT_W-1:0] ACTIVE_RST = 6'd32;

  localparam logic ACTION_ALLOC   = 1'b0;
  localparam logic ACTION_RELEASE = 1'b1;

  // register index, taken from the word address
  localparam logic REG_ACTIVE_SLOTS = 1'b0;

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // update map and counters, load result
  } fspa_cmd_t;

endpackage

`default_nettype wire

[rtl/fspa_ctrl.sv]
// Controller: accepts an item, runs the execute state, strobes the result.
`default_nettype none

module fspa_ctrl
  import fspa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output fspa_cmd_t cmd,
  output logic      out_valid
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic valid_r, valid_nxt;

  always_comb begin
    busy        = (state_r == S_EXEC);
    cmd.capture = start && !busy;
    cmd.exec    = (state_r == S_EXEC);
    valid_nxt   = cmd.exec;
    case (state_r)
      S_IDLE:  state_nxt = cmd.capture ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

[rtl/fspa_datapath.sv]
// Datapath: free map, lowest-free search, counters and the active-slots register.
`default_nettype none

module fspa_datapath
  import fspa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fspa_cmd_t         cmd,
  input  wire logic              in_action,
  input  wire logic [SLOT_W-1:0] in_release_slot,
  input  wire logic              cfg_we,
  input  wire logic [ACT_W-1:0]  cfg_wdata,
  output logic [ACT_W-1:0]       active_slots,
  output logic                   out_ok,
  output logic [SLOT_W-1:0]      out_granted_slot,
  output logic [CNT_W-1:0]       out_alloc_count,
  output logic [CNT_W-1:0]       out_release_count,
  output logic [CNT_W-1:0]       out_hit_count,
  output logic [CNT_W-1:0]       out_miss_count
);

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LIVE_W = $clog2(MAX_SLOTS + 1) + 1;
  localparam int CMP_W  = (LIVE_W > ACT_W + 1) ? LIVE_W : ACT_W + 1;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SLOTS);

  logic [ACT_W-1:0]     active_r;
  logic                 act_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [MAX_SLOTS-1:0] free_r, free_nxt;
  logic [CNT_W-1:0]     alloc_cnt_r, rel_cnt_r, hit_cnt_r, miss_cnt_r;
  logic                 ok_r, ok_nxt;
  logic [SLOT_W-1:0]    granted_r, granted_nxt;

  logic [CMP_W-1:0]     active_ext, live;
  logic [MAX_SLOTS-1:0] avail;
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic                 rel_ok;

  always_comb begin
    active_ext = CMP_W'(active_r);
    live       = (active_ext > MAX_CMP) ? MAX_CMP : active_ext;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      avail[i] = free_r[i] && (CMP_W'(i) < live);
    end
    // lowest set bit of the available map
    found     = 1'b0;
    found_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
    rel_ok = (CMP_W'(slot_r) < live);

    free_nxt    = free_r;
    ok_nxt      = 1'b0;
    granted_nxt = '0;
    if (act_r == ACTION_ALLOC) begin
      ok_nxt = found;
      if (found) begin
        granted_nxt = SLOT_W'(found_idx);
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (IDX_W'(i) == found_idx) free_nxt[i] = 1'b0;
        end
      end
    end else begin
      ok_nxt = rel_ok;
      if (rel_ok) begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (CMP_W'(i) == CMP_W'(slot_r)) free_nxt[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_RST;
      free_r      <= '1;
      alloc_cnt_r <= '0;
      rel_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      if (cfg_we) active_r <= cfg_wdata;
      if (cmd.exec) begin
        free_r <= free_nxt;
        if (act_r == ACTION_ALLOC) begin
          alloc_cnt_r <= alloc_cnt_r + 1'b1;
          if (found) hit_cnt_r  <= hit_cnt_r + 1'b1;
          else       miss_cnt_r <= miss_cnt_r + 1'b1;
        end else begin
          rel_cnt_r <= rel_cnt_r + 1'b1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      slot_r <= in_release_slot;
    end
    if (cmd.exec) begin
      ok_r      <= ok_nxt;
      granted_r <= granted_nxt;
    end
  end

  assign active_slots      = active_r;
  assign out_ok            = ok_r;
  assign out_granted_slot  = granted_r;
  assign out_alloc_count   = alloc_cnt_r;
  assign out_release_count = rel_cnt_r;
  assign out_hit_count     = hit_cnt_r;
  assign out_miss_count    = miss_cnt_r;

endmodule

`default_nettype wire

[rtl/fixed_slot_pool_allocator_unit.sv]
// Top level of the fixed slot pool allocator: APB register, controller, datapath.
//
//  channel   ports                                   handshake
//  input     in_action, in_release_slot               start & !busy
//  result    out_ok, out_granted_slot, out_*_count    out_valid, one cycle
//  config    psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// An item is latched when accepted; the execute state then searches the free
// map and updates the counters. The result strobes in the cycle after the
// execute state, and the next item may be accepted in that same cycle. busy
// is high in the execute cycle. Reset is synchronous: all slots free, counters
// zero, active 32. The receiver cannot stall; out_valid lasts one cycle.
`default_nettype none

module fixed_slot_pool_allocator_unit
  import fspa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_action,
  input  wire logic [SLOT_W-1:0] in_release_slot,
  output logic                   out_valid,
  output logic                   out_ok,
  output logic [SLOT_W-1:0]      out_granted_slot,
  output logic [CNT_W-1:0]       out_alloc_count,
  output logic [CNT_W-1:0]       out_release_count,
  output logic [CNT_W-1:0]       out_hit_count,
  output logic [CNT_W-1:0]       out_miss_count,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  fspa_cmd_t        cmd;
  logic             cfg_we;
  logic [ACT_W-1:0] active_slots;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_ACTIVE_SLOTS);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? APB_DW'(active_slots) : '0;

  fspa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  fspa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_action         (in_action),
    .in_release_slot   (in_release_slot),
    .cfg_we            (cfg_we),
    .cfg_wdata         (pwdata[ACT_W-1:0]),
    .active_slots      (active_slots),
    .out_ok            (out_ok),
    .out_granted_slot  (out_granted_slot),
    .out_alloc_count   (out_alloc_count),
    .out_release_count (out_release_count),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count)
  );

endmodule

`default_nettype wire

[rtl/fspa_checker.sv]
// Port-level checks for the allocator, bound to the top level.
`default_nettype none

module fspa_checker
  import fspa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic              out_ok,
  input wire logic [SLOT_W-1:0] out_granted_slot
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("busy held longer than one cycle");

  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid) else $error("result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without an item");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_granted_slot == '0)
    else $error("granted slot nonzero on refusal");

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_ok           (out_ok),
  .out_granted_slot (out_granted_slot)
);

`default_nettype wire
